/* rtl/core/sgn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgn_pkg
// Shared types, constants and helper functions of the Sobel gradient / NMS core.
// ----------------------------------------------------------------------------
package sgn_pkg;

   localparam int ROW_W       = 13;   // row counter, runs up to frame height + 2
   localparam int FW_BITS     = 11;
   localparam int FH_BITS     = 13;
   localparam int MIN_DIM     = 3;
   localparam int HEIGHT_MAX  = 4096;
   localparam int TAPS        = 9;
   localparam int CENTER_TAP  = 4;
   localparam int MAG_BITS    = 8;
   localparam int WEIGHT_BITS = 9;
   localparam int WEIGHT_ONE  = 256;
   localparam int GRAD_BITS   = 11;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_SUPPRESS      = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [FW_BITS-1:0] frame_width;
      logic [FH_BITS-1:0] frame_height;
      logic               suppress_enable;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LATCH,
      OP_DECODE,
      OP_PIX_TAP,
      OP_SQUARE,
      OP_SUM,
      OP_SQRT,
      OP_MAG_WR,
      OP_MAG_TAP,
      OP_PREP,
      OP_DIV,
      OP_CMP1,
      OP_CMP2,
      OP_EMIT,
      OP_ADVANCE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic drop_idle;
      logic drop_item;
      logic need_mag;
      logic need_out;
      logic out_busy;
   } dp_status_type;

   // three-row circular line stores
   function automatic logic [1:0] slot_inc(logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic logic [1:0] slot_dec(logic [1:0] s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

   // window taps are numbered row-major, top row first
   function automatic logic [1:0] tap_slot(logic [1:0] s, logic [3:0] k);
      logic [1:0] r;
      if (k < 4'd3) r = slot_dec(s);
      else if (k < 4'd6) r = s;
      else r = slot_inc(s);
      return r;
   endfunction

   function automatic logic signed [2:0] kx(logic [3:0] k);
      logic signed [2:0] c;
      case (k)
         4'd0, 4'd6: c = 3'sb001;
         4'd2, 4'd8: c = 3'sb111;
         4'd3:       c = 3'sb010;
         4'd5:       c = 3'sb110;
         default:    c = 3'sb000;
      endcase
      return c;
   endfunction

   function automatic logic signed [2:0] ky(logic [3:0] k);
      logic signed [2:0] c;
      case (k)
         4'd0, 4'd2: c = 3'sb001;
         4'd1:       c = 3'sb010;
         4'd6, 4'd8: c = 3'sb111;
         4'd7:       c = 3'sb110;
         default:    c = 3'sb000;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/sobel_gradient_nms_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_gradient_nms_core
// 3x3 Sobel magnitude with optional interpolated non-maximum suppression.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the req_ channel in raster order (req_cmd = 0); flush
//   items (req_cmd = 1) push the stream past the last pixel so the delayed
//   outputs drain. Each output belongs to the pixel 2*W+2 items earlier and
//   comes on the rsp_ channel; rsp_last_of_frame marks the end of the frame.
//   Geometry and the suppress flag are written over the APB port and are
//   sampled when a frame's first pixel is taken.
//   Items differ in length: a flush while idle is shortest, then an ignored
//   flush in a frame, other items that produce nothing, items that finish a
//   magnitude only, and items that produce an output take longest. The time
//   is set by the nine one-per-cycle line-store reads for the Sobel window and
//   for the magnitude window, the 8-step square root and the 9-step weight
//   divider, all run one after another by the sequencer.
//   An item may be accepted while the previous output waits in the output
//   register; if rsp_stall holds the register, the next output waits in
//   place and req_stall stays high until it can be loaded.
//   Reset returns the sequencer to idle, drops any pending output and sets
//   the registers to 640 x 480 with suppression on. Line stores need no
//   clearing pass.
// ----------------------------------------------------------------------------
module sobel_gradient_nms_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [7:0]                 req_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_edge_value,
   output logic                       rsp_last_of_frame,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sgn_pkg::ADDR_W-1:0] paddr,
   input  logic [sgn_pkg::DATA_W-1:0] pwdata,
   output logic [sgn_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import sgn_pkg::*;

   cfg_type       cfg_ff;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   reg_index_type reg_idx;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= FRAME_WIDTH_RST;
         cfg_ff.frame_height    <= FRAME_HEIGHT_RST;
         cfg_ff.suppress_enable <= 1'b1;
      end else if (wr_en) begin
         case (reg_idx)
            REG_FRAME_WIDTH:  cfg_ff.frame_width     <= pwdata[FW_BITS-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height    <= pwdata[FH_BITS-1:0];
            REG_SUPPRESS:     cfg_ff.suppress_enable <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_ff.frame_height);
         REG_SUPPRESS:     prdata = DATA_W'(cfg_ff.suppress_enable);
         default:          prdata = '0;
      endcase
   end

   sgn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   sgn_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_cmd           (req_cmd),
      .req_pixel         (req_pixel),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_edge_value    (rsp_edge_value),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
`default_nettype wire

/* rtl/core/sgn_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgn_ctrl
// Sequencer: walks one item through latch, Sobel taps, square root, window
// read, weight division, comparisons and output, skipping steps it does not need.
// ----------------------------------------------------------------------------
module sgn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sgn_pkg::dp_status_type status,
   output sgn_pkg::dp_cmd_type    cmd
);
   import sgn_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LATCH, S_DECODE, S_PIX, S_SQUARE, S_SUM, S_SQRT, S_MAGWR,
      S_MAGRD, S_PREP, S_DIV, S_CMP1, S_CMP2, S_EMIT, S_ADV
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       need_out_ff, need_out_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      need_out_in = need_out_ff;
      cmd.op      = OP_NONE;
      cmd.idx     = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_LATCH;
            end
         end
         S_LATCH: begin
            cmd.op   = OP_LATCH;
            state_in = status.drop_idle ? S_IDLE : S_DECODE;
         end
         S_DECODE: begin
            cmd.op      = OP_DECODE;
            need_out_in = status.need_out;
            cnt_in      = 4'd0;
            if (status.drop_item) state_in = S_IDLE;
            else if (status.need_mag) state_in = S_PIX;
            else state_in = S_ADV;
         end
         S_PIX: begin
            cmd.op = OP_PIX_TAP;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(TAPS)) state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.op   = OP_SQUARE;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            cnt_in   = 4'd0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(MAG_BITS - 1)) state_in = S_MAGWR;
         end
         S_MAGWR: begin
            cmd.op   = OP_MAG_WR;
            cnt_in   = 4'd0;
            state_in = need_out_ff ? S_MAGRD : S_ADV;
         end
         S_MAGRD: begin
            cmd.op = OP_MAG_TAP;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(TAPS)) state_in = S_PREP;
         end
         S_PREP: begin
            cmd.op   = OP_PREP;
            cnt_in   = 4'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(WEIGHT_BITS - 1)) state_in = S_CMP1;
         end
         S_CMP1: begin
            cmd.op   = OP_CMP1;
            state_in = S_CMP2;
         end
         S_CMP2: begin
            cmd.op   = OP_CMP2;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.op   = OP_EMIT;
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            cmd.op   = OP_ADVANCE;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= 4'd0;
         need_out_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         need_out_ff <= need_out_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/sgn_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgn_datapath
// Line stores, position counters, Sobel accumulator, iterative square root
// and weight divider, interpolated comparison and the output register.
// ----------------------------------------------------------------------------
module sgn_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sgn_pkg::cfg_type       cfg,
   input  sgn_pkg::dp_cmd_type    cmd,
   output sgn_pkg::dp_status_type status,
   input  logic                   req_cmd,
   input  logic [7:0]             req_pixel,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_edge_value,
   output logic                   rsp_last_of_frame
);
   import sgn_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);

   typedef logic [CW-1:0] col_type;
   typedef enum logic [1:0] {SEC_POS_FLAT, SEC_POS_STEEP, SEC_NEG_STEEP, SEC_NEG_FLAT}
      sector_type;

   function automatic col_type tap_col(col_type c, logic [3:0] k);
      col_type r;
      if (k == 4'd0 || k == 4'd3 || k == 4'd6) r = c - col_type'(1);
      else if (k == 4'd2 || k == 4'd5 || k == 4'd8) r = c + col_type'(1);
      else r = c;
      return r;
   endfunction

   // frame state
   logic                 active_ff;
   logic [WW-1:0]        w_ff;
   logic [FH_BITS-1:0]   h_ff;
   logic                 sup_ff;
   col_type              col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [1:0]           slot_ff;
   logic                 item_cmd_ff;
   logic [7:0]           item_pix_ff;

   // positions being worked on
   col_type              q_col_ff, o_col_ff;
   logic [1:0]           q_slot_ff, o_slot_ff;
   logic                 q_int_ff, o_int_ff, o_last_ff, need_out_ff;

   // memories
   logic [7:0]                 pix_mem  [3][MAX_WIDTH];
   logic [7:0]                 mag_mem  [3][MAX_WIDTH];
   logic [2*GRAD_BITS-1:0]     grad_mem [3][MAX_WIDTH];
   logic [7:0]                 pix_rd_ff, mag_rd_ff;
   logic [2*GRAD_BITS-1:0]     grad_rd_ff, grad_c_ff;
   op_type                     rd_op_ff;
   logic [3:0]                 rd_idx_ff;

   // arithmetic
   logic signed [GRAD_BITS-1:0] gx_ff, gy_ff;
   logic [19:0]                 sqx_ff, sqy_ff;
   logic [20:0]                 ss_ff;
   logic [MAG_BITS-1:0]         root_ff;
   logic [7:0]                  mwin_ff [TAPS];
   logic [9:0]                  mx_ff;
   logic [10:0]                 r_ff;
   logic [WEIGHT_BITS-1:0]      wt_ff;
   sector_type                  sector_ff;
   logic                        supp_flag_ff;
   logic                        out_full_ff;
   logic [7:0]                  out_edge_ff;
   logic                        out_last_ff;

   // geometry clamp
   logic [WW-1:0]      w_lim;
   logic [FH_BITS-1:0] h_lim;
   always_comb begin
      if (cfg.frame_width < FW_BITS'(MIN_DIM)) w_lim = WW'(MIN_DIM);
      else if (int'(cfg.frame_width) > MAX_WIDTH) w_lim = WW'(MAX_WIDTH);
      else w_lim = WW'(cfg.frame_width);
      if (cfg.frame_height < FH_BITS'(MIN_DIM)) h_lim = FH_BITS'(MIN_DIM);
      else if (int'(cfg.frame_height) > HEIGHT_MAX) h_lim = FH_BITS'(HEIGHT_MAX);
      else h_lim = cfg.frame_height;
   end

   // stream position decode
   logic             draining, col_ge1, col_ge2;
   logic [ROW_W-1:0] q_row, o_row;
   col_type          q_col, o_col, last_col;
   logic [1:0]       q_slot, o_slot;
   logic             q_int, o_int, o_last;
   logic [ROW_W-1:0] h_row, h_last;

   assign h_row    = ROW_W'(h_ff);
   assign h_last   = h_row - ROW_W'(1);
   assign last_col = CW'(w_ff - WW'(1));
   assign draining = (row_ff >= h_row);
   assign col_ge1  = (col_ff != '0);
   assign col_ge2  = (col_ff >= col_type'(2));

   always_comb begin
      q_row  = col_ge1 ? row_ff - ROW_W'(1) : row_ff - ROW_W'(2);
      q_col  = col_ge1 ? col_ff - col_type'(1) : last_col;
      q_slot = col_ge1 ? slot_dec(slot_ff) : slot_inc(slot_ff);
      o_row  = col_ge2 ? row_ff - ROW_W'(2) : row_ff - ROW_W'(3);
      if (col_ge2) o_col = col_ff - col_type'(2);
      else if (col_ge1) o_col = last_col;
      else o_col = last_col - col_type'(1);
      o_slot = col_ge2 ? slot_inc(slot_ff) : slot_ff;
      q_int  = (q_row != '0) && (q_row < h_last) && (q_col != '0)
               && (WW'(q_col) < w_ff - WW'(1));
      o_int  = (o_row != '0) && (o_row < h_last) && (o_col != '0)
               && (WW'(o_col) < w_ff - WW'(1));
      o_last = (o_row == h_last) && (o_col == last_col);
   end

   assign status.drop_idle = !active_ff && item_cmd_ff;
   assign status.drop_item = !draining && item_cmd_ff;
   assign status.need_mag  = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ge1);
   assign status.need_out  = (row_ff >= ROW_W'(3)) || (row_ff == ROW_W'(2) && col_ge2);
   assign status.out_busy  = out_full_ff && rsp_stall;

   // frame control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_LATCH && !active_ff && !item_cmd_ff) begin
            active_ff <= 1'b1;
         end else if (cmd.op == OP_ADVANCE && need_out_ff && o_last_ff) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         item_cmd_ff <= req_cmd;
         item_pix_ff <= req_pixel;
      end
      if (cmd.op == OP_LATCH && !active_ff && !item_cmd_ff) begin
         w_ff    <= w_lim;
         h_ff    <= h_lim;
         sup_ff  <= cfg.suppress_enable;
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= 2'd0;
      end
      if (cmd.op == OP_DECODE) begin
         q_col_ff    <= q_col;
         q_slot_ff   <= q_slot;
         q_int_ff    <= q_int;
         o_col_ff    <= o_col;
         o_slot_ff   <= o_slot;
         o_int_ff    <= o_int;
         o_last_ff   <= o_last;
         need_out_ff <= status.need_out;
      end
      if (cmd.op == OP_ADVANCE && !(need_out_ff && o_last_ff)) begin
         if (WW'(col_ff) + WW'(1) >= w_ff) begin
            col_ff  <= '0;
            row_ff  <= row_ff + ROW_W'(1);
            slot_ff <= slot_inc(slot_ff);
         end else begin
            col_ff <= col_ff + col_type'(1);
         end
      end
   end

   // line stores
   always_ff @(posedge clock) begin
      if (cmd.op == OP_DECODE && !status.drop_item) begin
         pix_mem[slot_ff][col_ff] <= draining ? 8'd0 : item_pix_ff;
      end
      pix_rd_ff <= pix_mem[tap_slot(q_slot_ff, cmd.idx)][tap_col(q_col_ff, cmd.idx)];
   end

   logic [7:0] mag_val;
   assign mag_val = !q_int_ff ? 8'd0 : ((ss_ff[20:16] != '0) ? 8'hFF : root_ff);

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MAG_WR) begin
         mag_mem[q_slot_ff][q_col_ff]  <= mag_val;
         grad_mem[q_slot_ff][q_col_ff] <= q_int_ff ? {gx_ff, gy_ff} : '0;
      end
      mag_rd_ff  <= mag_mem[tap_slot(o_slot_ff, cmd.idx)][tap_col(o_col_ff, cmd.idx)];
      grad_rd_ff <= grad_mem[o_slot_ff][o_col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_op_ff  <= OP_NONE;
         rd_idx_ff <= 4'd0;
      end else begin
         rd_op_ff  <= cmd.op;
         rd_idx_ff <= cmd.idx;
      end
   end

   // Sobel accumulation and magnitude window capture, one tap per cycle
   always_ff @(posedge clock) begin
      if (cmd.op == OP_DECODE) begin
         gx_ff <= '0;
         gy_ff <= '0;
      end else if (rd_op_ff == OP_PIX_TAP && rd_idx_ff < 4'(TAPS)) begin
         gx_ff <= gx_ff + kx(rd_idx_ff) * $signed({3'b000, pix_rd_ff});
         gy_ff <= gy_ff + ky(rd_idx_ff) * $signed({3'b000, pix_rd_ff});
      end
      if (rd_op_ff == OP_MAG_TAP && rd_idx_ff < 4'(TAPS)) begin
         mwin_ff[rd_idx_ff] <= mag_rd_ff;
         if (rd_idx_ff == 4'(CENTER_TAP)) grad_c_ff <= grad_rd_ff;
      end
   end

   // squares and bitwise square root
   logic signed [21:0]  gx2, gy2;
   logic [2:0]          sqrt_bit;
   logic [MAG_BITS-1:0] trial;
   logic [15:0]         trial_sq;

   assign gx2      = gx_ff * gx_ff;
   assign gy2      = gy_ff * gy_ff;
   assign sqrt_bit = 3'(4'(MAG_BITS - 1) - cmd.idx);
   assign trial    = root_ff | (MAG_BITS'(1) << sqrt_bit);
   assign trial_sq = trial * trial;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_SQUARE: begin
            sqx_ff <= gx2[19:0];
            sqy_ff <= gy2[19:0];
         end
         OP_SUM: begin
            ss_ff   <= 21'(sqx_ff) + 21'(sqy_ff);
            root_ff <= '0;
         end
         OP_SQRT: begin
            if (trial_sq <= ss_ff[15:0]) root_ff <= trial;
         end
         default: ;
      endcase
   end

   // direction sector and interpolation weight
   logic signed [GRAD_BITS-1:0] cgx, cgy;
   logic [9:0]                  ax, ay, mx, mn;
   logic                        steep, pos;
   sector_type                  sector;

   always_comb begin
      cgx   = grad_c_ff[2*GRAD_BITS-1:GRAD_BITS];
      cgy   = grad_c_ff[GRAD_BITS-1:0];
      ax    = cgx[GRAD_BITS-1] ? 10'(-cgx) : 10'(cgx);
      ay    = cgy[GRAD_BITS-1] ? 10'(-cgy) : 10'(cgy);
      steep = cgx[GRAD_BITS-1] ? (ay >= ax) : (ay > ax);
      pos   = (cgy == '0) || (!cgy[GRAD_BITS-1] && !cgx[GRAD_BITS-1])
              || (cgy[GRAD_BITS-1] && cgx[GRAD_BITS-1]);
      mx    = (ax > ay) ? ax : ay;
      mn    = (ax > ay) ? ay : ax;
      if (pos) sector = steep ? SEC_POS_STEEP : SEC_POS_FLAT;
      else sector = steep ? SEC_NEG_STEEP : SEC_NEG_FLAT;
   end

   // neighbor pairs
   logic [7:0] a1, d1, a2, d2, pa, pd;
   always_comb begin
      unique case (sector_ff)
         SEC_POS_FLAT: begin
            a1 = mwin_ff[5]; d1 = mwin_ff[2]; a2 = mwin_ff[3]; d2 = mwin_ff[6];
         end
         SEC_POS_STEEP: begin
            a1 = mwin_ff[1]; d1 = mwin_ff[2]; a2 = mwin_ff[7]; d2 = mwin_ff[6];
         end
         SEC_NEG_STEEP: begin
            a1 = mwin_ff[1]; d1 = mwin_ff[0]; a2 = mwin_ff[7]; d2 = mwin_ff[8];
         end
         SEC_NEG_FLAT: begin
            a1 = mwin_ff[3]; d1 = mwin_ff[0]; a2 = mwin_ff[5]; d2 = mwin_ff[8];
         end
         default: begin
            a1 = mwin_ff[3]; d1 = mwin_ff[0]; a2 = mwin_ff[5]; d2 = mwin_ff[8];
         end
      endcase
      pa = (cmd.op == OP_CMP2) ? a2 : a1;
      pd = (cmd.op == OP_CMP2) ? d2 : d1;
   end

   logic [WEIGHT_BITS-1:0] w_eff, w_cmp;
   logic [16:0]            prod_a, prod_d, rhs, lhs;

   assign w_eff  = (mx_ff == '0) ? '0 : wt_ff;
   assign w_cmp  = WEIGHT_BITS'(WEIGHT_ONE) - w_eff;
   assign prod_a = w_eff * pa;
   assign prod_d = w_cmp * pd;
   assign rhs    = prod_a + prod_d;
   assign lhs    = {1'b0, mwin_ff[CENTER_TAP], 8'd0};

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_PREP: begin
            mx_ff        <= mx;
            r_ff         <= 11'(mn);
            wt_ff        <= '0;
            sector_ff    <= sector;
            supp_flag_ff <= 1'b0;
         end
         OP_DIV: begin
            // restoring long division of mn by mx, one quotient bit a step
            if (r_ff >= 11'(mx_ff)) begin
               wt_ff <= {wt_ff[WEIGHT_BITS-2:0], 1'b1};
               r_ff  <= (r_ff - 11'(mx_ff)) << 1;
            end else begin
               wt_ff <= {wt_ff[WEIGHT_BITS-2:0], 1'b0};
               r_ff  <= r_ff << 1;
            end
         end
         OP_CMP1, OP_CMP2: begin
            if (lhs < rhs) supp_flag_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         out_full_ff <= 1'b1;
      end else if (out_full_ff && !rsp_stall) begin
         out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         out_edge_ff <= (!o_int_ff || (sup_ff && supp_flag_ff)) ? 8'd0
                        : mwin_ff[CENTER_TAP];
         out_last_ff <= o_last_ff;
      end
   end

   assign rsp_valid         = out_full_ff;
   assign rsp_edge_value    = out_edge_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule
`default_nettype wire
